[rtl/core/motor_speed_pid_defines.svh]
// ---------------------------------------------------------------------------
// motor_speed_pid_defines.svh
// assertion macros for the motor speed regulator
// ---------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PID_DEFINES_SVH
`define MOTOR_SPEED_PID_DEFINES_SVH

`ifndef SYNTH
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSP_ASSERT_NOW(lbl, ante, cons, msg)
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/msp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msp_pkg
// shared types and constants of the motor speed regulator
// ---------------------------------------------------------------------------
package msp_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int INTEGRAL_LIMIT = 5000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 3'd4;

  // mode codes
  localparam logic [2:0] MODE_RUN   = 3'd0;
  localparam logic [2:0] MODE_BRAKE = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_FREE  = 3'd3;

  localparam logic [2:0]  MODE_RST       = MODE_FREE;
  localparam logic [15:0] GAIN_RST       = 16'd1024;
  localparam logic [14:0] DUTY_LIMIT_RST = 15'd1000;

  typedef enum logic [2:0] {
    DRIVE_HOLD  = 3'd0,
    DRIVE_FWD   = 3'd1,
    DRIVE_BACK  = 3'd2,
    DRIVE_BRAKE = 3'd3,
    DRIVE_COAST = 3'd4
  } drive_t;

endpackage

[rtl/core/motor_speed_pid.sv]
`timescale 1ns / 1ps
// stages: input register, then result register
// throughput: one request per cycle while out_stall is low; the pid law, state update
//   and result are formed in one pass between the two registers, p+i-d gain products
// reset: synchronous active-low rst_n clears both stages, the encoder, speed,
//   integral and action state, and loads the register defaults
// ---------------------------------------------------------------------------
// motor_speed_pid
// pid speed regulator: wrapped speed measure, q-format pid law, duty and
// direction selection per operating mode
// ---------------------------------------------------------------------------
`include "motor_speed_pid_defines.svh"

module motor_speed_pid (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  in_enc_count,
  input  logic signed [15:0]                  in_target_speed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [14:0]                         out_duty,
  output logic [2:0]                          out_drive,
  output logic signed [15:0]                  out_speed
);
  import msp_pkg::*;

  localparam int ACC_W = 35;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);
  localparam logic signed [16:0]      INT_HI   = 17'(INTEGRAL_LIMIT);
  localparam logic signed [16:0]      INT_LO   = -17'(INTEGRAL_LIMIT);

  // configuration
  logic [2:0]  mode_r;
  logic [15:0] gain_p_r;
  logic [15:0] gain_i_r;
  logic [15:0] gain_d_r;
  logic [14:0] duty_limit_r;

  // input stage
  logic               in_vld_r;
  logic signed [31:0] in_count_r;
  logic signed [15:0] in_target_r;

  // regulator state
  logic [31:0]        prev_count_r;
  logic signed [15:0] prev_speed_r;
  logic signed [13:0] integral_r;
  logic signed [15:0] action_r;

  // result stage
  logic               out_vld_r;
  logic [14:0]        duty_r;
  drive_t             drive_r;
  logic signed [15:0] speed_r;

  logic adv;
  logic fire;

  logic signed [15:0] speed_w;
  logic signed [15:0] err_w;
  logic signed [15:0] dspd_w;
  logic signed [32:0] prod_p;
  logic signed [32:0] prod_i;
  logic signed [32:0] prod_d;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [15:0] val16;
  logic signed [16:0] val17;
  logic [16:0]        val_mag;
  logic signed [16:0] int_sum;
  logic signed [13:0] integral_nxt;
  logic signed [15:0] action_nxt;
  logic signed [15:0] prev_speed_nxt;
  logic [15:0]        action_mag;
  drive_t             drive_nxt;

  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_RST;
      gain_p_r     <= GAIN_RST;
      gain_i_r     <= GAIN_RST;
      gain_d_r     <= GAIN_RST;
      duty_limit_r <= DUTY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode_r       <= cfg_wdata[2:0];
        REG_GAIN_P:     gain_p_r     <= cfg_wdata;
        REG_GAIN_I:     gain_i_r     <= cfg_wdata;
        REG_GAIN_D:     gain_d_r     <= cfg_wdata;
        REG_DUTY_LIMIT: duty_limit_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_count_r  <= in_enc_count;
      in_target_r <= in_target_speed;
    end
  end

  always_comb begin
    // speed is the low half of the count difference
    speed_w = in_count_r[15:0] - prev_count_r[15:0];
    err_w   = in_target_r - speed_w;
    dspd_w  = speed_w - prev_speed_r;

    prod_p = $signed({1'b0, gain_p_r}) * err_w;
    prod_i = $signed({1'b0, gain_i_r}) * integral_r;
    prod_d = $signed({1'b0, gain_d_r}) * dspd_w;
    acc    = ACC_W'(prod_p) + ACC_W'(prod_i) - ACC_W'(prod_d);

    // truncate toward zero on the fraction drop
    acc_adj = acc + (acc[ACC_W-1] ? RND_BIAS : '0);
    acc_shr = acc_adj >>> GAIN_FRAC_BITS;

    if (acc_shr > SAT_HI) begin
      val16 = 16'sh7fff;
    end else if (acc_shr < SAT_LO) begin
      val16 = 16'sh8000;
    end else begin
      val16 = acc_shr[15:0];
    end
    val17   = 17'(val16);
    val_mag = val17[16] ? 17'(-val17) : 17'(val17);

    int_sum = 17'(integral_r) + 17'(err_w);
    if (int_sum > INT_HI) begin
      integral_nxt = INT_HI[13:0];
    end else if (int_sum < INT_LO) begin
      integral_nxt = INT_LO[13:0];
    end else begin
      integral_nxt = int_sum[13:0];
    end

    action_nxt     = action_r;
    prev_speed_nxt = prev_speed_r;
    drive_nxt      = DRIVE_HOLD;
    unique case (mode_r)
      MODE_RUN: begin
        drive_nxt      = (val16 > 16'sd0) ? DRIVE_FWD : DRIVE_BACK;
        // an oversized value of either sign takes the positive limit
        action_nxt     = (val_mag > {2'b00, duty_limit_r}) ? {1'b0, duty_limit_r} : val16;
        prev_speed_nxt = speed_w;
      end
      MODE_STOP: begin
        drive_nxt  = DRIVE_BRAKE;
        action_nxt = {1'b0, duty_limit_r};
      end
      MODE_FREE: begin
        drive_nxt  = DRIVE_COAST;
        action_nxt = '0;
      end
      default: ;
    endcase
    action_mag = action_nxt[15] ? 16'(-action_nxt) : action_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      prev_speed_r <= '0;
      integral_r   <= '0;
      action_r     <= '0;
    end else if (fire) begin
      prev_count_r <= in_count_r;
      prev_speed_r <= prev_speed_nxt;
      action_r     <= action_nxt;
      if (mode_r == MODE_RUN) begin
        integral_r <= integral_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      duty_r  <= action_mag[14:0];
      drive_r <= drive_nxt;
      speed_r <= speed_w;
    end
  end

  assign out_valid = out_vld_r;
  assign out_duty  = duty_r;
  assign out_drive = drive_r;
  assign out_speed = speed_r;

  `MSP_ASSERT_NOW(a_integral_range, 1'b1, (integral_r <= 14'sd5000) && (integral_r >= -14'sd5000), "integral out of range")
  `MSP_ASSERT_NEXT(a_fire_gives_result, fire, out_vld_r, "request processed without result")
  `MSP_ASSERT_NEXT(a_run_speed_kept, fire && (mode_r == MODE_RUN), prev_speed_r == speed_r, "running speed not stored")
  `MSP_ASSERT_NOW(a_coast_zero_duty, out_vld_r && (drive_r == DRIVE_COAST), duty_r == 15'd0, "coast with nonzero duty")

endmodule
